FILE: rtl/core/actr_pkg.sv
// Shared types, constants and AES round functions for the CTR stream decryptor.
package actr_pkg;

	localparam int QueueDepth = 4;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int AesRounds  = 10;

	localparam logic [7:0] CFG_KEY_HIGH = 8'd0;
	localparam logic [7:0] CFG_KEY_LOW  = 8'd1;
	localparam logic [7:0] CFG_IV_HIGH  = 8'd2;
	localparam logic [7:0] CFG_IV_LOW   = 8'd3;

	typedef struct packed {
		logic [127:0] ctr;
		logic [3:0]   pos;
		logic         refresh;
		logic [7:0]   cbyte;
		logic         last;
	} actr_item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [AesRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] xtime(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Next AES-128 round key from the current one.
	function automatic logic [127:0] key_expand(logic [127:0] rk, logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
		w0 = rk[127:96] ^ t;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
	function automatic logic [127:0] aes_round(logic [127:0] st, logic [127:0] rk, logic mix);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[j + 4*c] = SBOX[s[j + 4*((c + j) % 4)]];
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
		return res;
	endfunction

endpackage

FILE: rtl/core/actr_front.sv
// Front end: tracks counter and keystream position and issues one work item per byte.
module actr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           cipher_byte,
	input  logic                 first_byte,
	input  logic                 last_byte,
	input  logic [63:0]          start_offset,
	input  logic [127:0]         iv,
	output logic                 push,
	output actr_pkg::actr_item_t item,
	input  logic                 queue_ready
);
	import actr_pkg::*;

	logic [127:0] ctr_q;
	logic [3:0]   pos_q;
	logic [127:0] base, addend, ctr_use, ctr_inc;
	logic [3:0]   pos_use;

	assign in_ready = queue_ready;
	assign push     = in_valid && queue_ready;

	// Two parallel adders: the block counter used now and the one after a wrap.
	always_comb begin
		base    = first_byte ? iv : ctr_q;
		addend  = first_byte ? {68'd0, start_offset[63:4]} : 128'd0;
		ctr_use = base + addend;
		ctr_inc = base + addend + 128'd1;
		pos_use = first_byte ? start_offset[3:0] : pos_q;
		item.ctr     = ctr_use;
		item.pos     = pos_use;
		item.refresh = first_byte || (pos_use == 4'd0);
		item.cbyte   = cipher_byte;
		item.last    = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= '0;
		end else if (push) begin
			ctr_q <= (pos_use == 4'd15) ? ctr_inc : ctr_use;
			pos_q <= pos_use + 4'd1;
		end
	end
endmodule

FILE: rtl/core/actr_queue.sv
// Small register queue between the front end and the AES back end.
module actr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  actr_pkg::actr_item_t push_item,
	output logic                 not_full,
	input  logic                 pop,
	output logic                 not_empty,
	output actr_pkg::actr_item_t pop_item
);
	import actr_pkg::*;

	actr_item_t      mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   count_q;

	assign not_full  = (count_q != (PtrW+1)'(QueueDepth));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW+1)'(QueueDepth)) else $error("queue count above depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full) else $error("push into full queue");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("count not advanced");
endmodule

FILE: rtl/core/actr_back.sv
// Back end: pipelined AES-128 with on-the-fly key schedule, keystream hold and output register.
module actr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [127:0]         key,
	input  logic                 item_valid,
	input  actr_pkg::actr_item_t item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           plain_byte,
	output logic                 message_end
);
	import actr_pkg::*;

	logic         advance;
	logic         valid_s [AesRounds+1];
	logic [127:0] state_s [AesRounds+1];
	logic [127:0] rk_s    [AesRounds+1];
	actr_item_t   meta_s  [AesRounds+1];
	logic [127:0] ks_q, ks_use, ks_shift;
	logic         out_valid_q, last_q;
	logic [7:0]   plain_q;

	// The whole pipeline moves together whenever the output register can take a transfer.
	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (advance) valid_s[0] <= pop;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s[0] <= item.ctr ^ key;
			rk_s[0]    <= key;
			meta_s[0]  <= item;
		end
	end

	for (genvar r = 1; r <= AesRounds; r++) begin : g_round
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[r] <= 1'b0;
			else if (advance) valid_s[r] <= valid_s[r-1];
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				rk_s[r]    <= key_expand(rk_s[r-1], RCON[r-1]);
				state_s[r] <= aes_round(state_s[r-1], key_expand(rk_s[r-1], RCON[r-1]),
					r < AesRounds);
				meta_s[r]  <= meta_s[r-1];
			end
		end
	end

	// A byte without refresh keeps using the block captured at the last refresh.
	always_comb begin
		ks_use   = meta_s[AesRounds].refresh ? state_s[AesRounds] : ks_q;
		ks_shift = ks_use << {meta_s[AesRounds].pos, 3'b000};
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s[AesRounds]) begin
			ks_q    <= ks_use;
			plain_q <= meta_s[AesRounds].cbyte ^ ks_shift[127:120];
			last_q  <= meta_s[AesRounds].last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= valid_s[AesRounds];
	end

	assign out_valid   = out_valid_q;
	assign plain_byte  = plain_q;
	assign message_end = last_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(plain_q))
		else $error("result dropped while stalled");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(valid_s[AesRounds])) else $error("pipeline moved while stalled");
	a_pop_adv: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> advance && item_valid) else $error("pop without advance");
endmodule

FILE: rtl/core/aes128_ctr_stream_decrypt_core.sv
// Top level of the AES-128 counter-mode stream decryptor.
// Decrypts one ciphertext byte per clock cycle, sustained while the result side is ready.
// Each byte passes one queue register, eleven AES pipeline stages and one output register.
// The rate is set by the ten-round AES pipeline, which computes a full round and the next round
// key in each round stage, so every byte may start a new counter block. The key and IV
// registers must be written only while no bytes are in flight; a key change in the middle of a
// block takes effect at the next block boundary or first byte of a message.
module aes128_ctr_stream_decrypt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // [7:0] cipher_byte, [71:8] start_offset
	input  logic [0:0]  s_axis_tuser,  // [0] first_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] plain_byte
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import actr_pkg::*;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        push, q_not_full, q_not_empty, pop;
	actr_item_t  push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_IV_HIGH:  iv_high_q  <= cfg_data;
				CFG_IV_LOW:   iv_low_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	actr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.cipher_byte  (s_axis_tdata[7:0]),
		.first_byte   (s_axis_tuser[0]),
		.last_byte    (s_axis_tlast),
		.start_offset (s_axis_tdata[71:8]),
		.iv           ({iv_high_q, iv_low_q}),
		.push         (push),
		.item         (push_item),
		.queue_ready  (q_not_full)
	);

	actr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	actr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         ({key_high_q, key_low_q}),
		.item_valid  (q_not_empty),
		.item        (pop_item),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.plain_byte  (m_axis_tdata),
		.message_end (m_axis_tlast)
	);
endmodule

FILE: sim/actr_checker.sv
// Checker for the CTR stream decryptor: predicts every plaintext byte and compares the results.
module actr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] plain;
		logic       msg_end;
	} plain_t;

	plain_t       plain_q[$];
	logic [7:0]   sbox_tbl [256];
	logic [127:0] key_reg, iv_reg, ctr_blk, ks_blk;
	logic [3:0]   ks_pos;

	function automatic logic [7:0] gf_x2(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = gf_x2(a);
			b = b >> 1;
		end
		return p;
	endfunction

	// The S-box is rebuilt from the field inverse and the affine map.
	initial begin
		logic [7:0]  inv;
		logic [15:0] dbl;
		logic [7:0]  s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
			dbl = {inv, inv};
			s = inv ^ 8'h63;
			for (int n = 1; n <= 4; n++) s ^= 8'(dbl >> (8 - n));
			sbox_tbl[x] = s;
		end
	end

	function automatic logic [127:0] aes_encrypt(logic [127:0] key, logic [127:0] blk);
		logic [7:0]   rk [176];
		logic [7:0]   st [16];
		logic [7:0]   tmp [16];
		logic [7:0]   t [4];
		logic [7:0]   f, rc, a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) rk[i] = key[127 - 8*i -: 8];
		rc = 8'h01;
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
			if (i % 16 == 0) begin
				f = t[0];
				t[0] = sbox_tbl[t[1]] ^ rc;
				t[1] = sbox_tbl[t[2]];
				t[2] = sbox_tbl[t[3]];
				t[3] = sbox_tbl[f];
				rc = gf_x2(rc);
			end
			for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ t[j];
		end
		for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					tmp[j + 4*c] = sbox_tbl[st[j + 4*((c + j) % 4)]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					tmp[4*c]   = a0 ^ all ^ gf_x2(a0 ^ a1);
					tmp[4*c+1] = a1 ^ all ^ gf_x2(a1 ^ a2);
					tmp[4*c+2] = a2 ^ all ^ gf_x2(a2 ^ a3);
					tmp[4*c+3] = a3 ^ all ^ gf_x2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*r + i];
		end
		for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		plain_t     got, want;
		logic [7:0] cb;
		logic [63:0] off;
		if (!arst_n) begin
			plain_q.delete();
			key_reg  = '0;
			iv_reg   = '0;
			ctr_blk  = '0;
			ks_blk   = '0;
			ks_pos   = '0;
			failures = 0;
			pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					actr_pkg::CFG_KEY_HIGH: key_reg[127:64] = cfg_data;
					actr_pkg::CFG_KEY_LOW:  key_reg[63:0]   = cfg_data;
					actr_pkg::CFG_IV_HIGH:  iv_reg[127:64]  = cfg_data;
					actr_pkg::CFG_IV_LOW:   iv_reg[63:0]    = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cb  = s_axis_tdata[7:0];
				off = s_axis_tdata[71:8];
				if (s_axis_tuser[0]) begin
					ctr_blk = iv_reg + {64'd0, off >> 4};
					ks_pos  = off[3:0];
				end
				if (s_axis_tuser[0] || ks_pos == 4'd0) ks_blk = aes_encrypt(key_reg, ctr_blk);
				want.plain   = cb ^ ks_blk[127 - 8*ks_pos -: 8];
				want.msg_end = s_axis_tlast;
				plain_q.push_back(want);
				ks_pos = ks_pos + 4'd1;
				if (ks_pos == 4'd0) ctr_blk = ctr_blk + 128'd1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.plain   = m_axis_tdata;
				got.msg_end = m_axis_tlast;
				if (plain_q.size() == 0) begin
					$display("%0t: unexpected result, actual byte %02h end %0b",
						$time, got.plain, got.msg_end);
					failures++;
				end else begin
					want = plain_q.pop_front();
					if (got.plain !== want.plain) begin
						$display("%0t: plain byte mismatch, expected %02h actual %02h",
							$time, want.plain, got.plain);
						failures++;
					end
					if (got.msg_end !== want.msg_end) begin
						$display("%0t: message end mismatch, expected %0b actual %0b",
							$time, want.msg_end, got.msg_end);
						failures++;
					end
				end
			end
			pending = plain_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// Top of the CTR stream decryptor testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CfgNoReg  = 8'd4;
	localparam logic [7:0] CfgAllOne = 8'hFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int          failures, pending;

	bit tx_fast = 0;
	bit rx_fast = 0;
	int rx_hold = 0;
	int sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aes128_ctr_stream_decrypt_core dut (.*);

	actr_checker chk (.*);

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// Result side: a random stall before each result, or one long hold-off on request.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = rx_fast ? 0 : $urandom_range(0, 13);
			if (rx_hold > 0) begin
				w = rx_hold;
				rx_hold = 0;
			end
			if (w > 0) begin
				m_axis_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_byte(logic [7:0] cb, bit first, bit last, logic [63:0] off);
		int w;
		w = tx_fast ? 0 : $urandom_range(0, 13);
		if (w > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (w - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {off, cb};
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// Stops offering and waits until every byte in flight has come back.
	task automatic drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic load_key_iv(logic [127:0] key, logic [127:0] iv);
		write_reg(actr_pkg::CFG_KEY_HIGH, key[127:64]);
		write_reg(actr_pkg::CFG_KEY_LOW, key[63:0]);
		write_reg(actr_pkg::CFG_IV_HIGH, iv[127:64]);
		write_reg(actr_pkg::CFG_IV_LOW, iv[63:0]);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_message(int len, logic [63:0] off);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), i == 0, i == len - 1, off);
	endtask

	initial begin
		int len;
		logic [63:0] off;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// No message start after reset: counter and key are both zero.
		send_byte(8'h00, 0, 0, '1);
		send_byte(8'hFF, 0, 1, '0);
		send_byte(8'hA5, 0, 0, '0);
		drain();

		load_key_iv('1, '1);
		write_reg(CfgNoReg, rand64());
		write_reg(CfgAllOne, rand64());
		// Offset addition carries into the high half and the counter wraps.
		send_byte(8'h00, 1, 0, 64'h0000_0000_0000_001F);
		send_byte(8'hFF, 0, 0, '0);
		send_byte(8'h3C, 0, 1, '0);
		send_byte(8'h11, 1, 0, '1);
		send_byte(8'h22, 0, 0, '0);
		// A new message start in the middle of a message.
		send_byte(8'h33, 1, 0, 64'd5);
		send_byte(8'h44, 0, 1, '0);
		// Bytes after the end of a message simply continue the stream.
		send_byte(8'h55, 0, 0, '0);
		send_byte(8'h66, 0, 0, '0);
		drain();

		// Key change in the middle of a block shows only at the next refresh.
		load_key_iv('0, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0});
		for (int i = 0; i < 14; i++) send_byte(8'($urandom), 0, 0, rand64());
		drain();

		while (sent < 630) begin
			if (sent % 130 < 20) begin
				drain();
				load_key_iv({rand64(), rand64()}, {rand64(), rand64()});
			end
			tx_fast = (sent % 200) > 150;
			rx_fast = (sent % 300) > 240;
			if (sent > 300 && sent < 320) begin
				// Hold the result side off long enough for the block to back up.
				drain();
				rx_hold = 300;
				tx_fast = 1;
				send_message(60, $urandom_range(0, 255));
				tx_fast = 0;
			end
			len = $urandom_range(1, 40);
			case ($urandom_range(0, 9))
				0: off = rand64();
				1: off = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
				default: off = $urandom_range(0, 300);
			endcase
			if ($urandom_range(0, 9) == 0)
				send_byte(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1), rand64());
			else
				send_message(len, off);
		end

		drain();
		repeat (30) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/actr_pkg.sv
rtl/core/actr_front.sv
rtl/core/actr_queue.sv
rtl/core/actr_back.sv
rtl/core/aes128_ctr_stream_decrypt_core.sv
sim/actr_checker.sv
sim/testbench.sv
